// File: rtl/core/ecgbd_pkg.sv
// ----------------------------------------------------------------------------
// ecgbd_pkg - shared types and constants of the ECG bar display driver
// Widths, register indexes, item kinds, LED cell commands and the bar lookup.
// ----------------------------------------------------------------------------
package ecgbd_pkg;

   // Filter window and LED bar size; WINDOW must stay a power of two
   localparam int WINDOW    = 8;
   localparam int LED_COUNT = 8;
   localparam int BAR_SPAN  = 585;

   localparam int SAMPLE_W  = 13;
   localparam int VALUE_W   = 12;
   localparam int WIN_W     = $clog2(WINDOW);
   localparam int SUM_W     = VALUE_W + WIN_W;
   localparam int LED_W     = $clog2(LED_COUNT);
   localparam int DUTY_W    = 8;
   localparam int PIN_W     = 3;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH_DIV  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_LEVEL = 2'd2;

   localparam logic [CFG_W-1:0] DECAY_STEP_RESET   = 8'd50;
   localparam logic [CFG_W-1:0] REFRESH_DIV_RESET  = 8'd3;
   localparam logic [CFG_W-1:0] MARKER_LEVEL_RESET = 8'd255;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef enum logic [1:0] {
      LED_HOLD,
      LED_REFRESH,
      LED_CLEAR,
      LED_ROTATE
   } led_op_type;

   typedef struct packed {
      led_op_type            op;
      logic [DUTY_W-1:0]     decay_step;
      logic [DUTY_W-1:0]     marker_level;
   } led_ctl_type;

   // LED lit by the bar: LED_COUNT - min(avg / BAR_SPAN + 1, LED_COUNT - 1)
   function automatic logic [LED_W-1:0] bar_led(input logic [VALUE_W-1:0] avg);
      int bar;
      bar = 1;
      for (int k = 1; k < LED_COUNT - 1; k++) begin
         if (int'(avg) >= k * BAR_SPAN) bar = bar + 1;
      end
      return LED_W'(LED_COUNT - bar);
   endfunction

endpackage

// File: rtl/core/ecgbd_ring_cell.sv
// ----------------------------------------------------------------------------
// ecgbd_ring_cell - one tap of the sample window
// Holds one clamped sample and takes its neighbor's value on each new sample.
// ----------------------------------------------------------------------------
module ecgbd_ring_cell
   import ecgbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic [VALUE_W-1:0] value_prev,
   output logic [VALUE_W-1:0] value
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = shift ? value_prev : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// File: rtl/core/ecgbd_led_cell.sv
// ----------------------------------------------------------------------------
// ecgbd_led_cell - one LED duty of the bar
// Decays or marks its duty on refresh, clears on leads-off, rotates on frames.
// ----------------------------------------------------------------------------
module ecgbd_led_cell
   import ecgbd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  led_ctl_type       ctl,
   input  logic              is_marker,
   input  logic [DUTY_W-1:0] duty_next,
   output logic [DUTY_W-1:0] duty
);

   logic [DUTY_W-1:0] duty_ff;
   logic [DUTY_W-1:0] duty_in;
   logic [DUTY_W-1:0] decayed;

   always_comb begin
      // saturating decay toward zero
      decayed = (duty_ff > ctl.decay_step) ? duty_ff - ctl.decay_step : '0;
      case (ctl.op)
         LED_HOLD:    duty_in = duty_ff;
         LED_REFRESH: duty_in = is_marker ? ctl.marker_level : decayed;
         LED_CLEAR:   duty_in = '0;
         LED_ROTATE:  duty_in = duty_next;
         default:     duty_in = duty_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else begin
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;

endmodule

// File: rtl/core/ecg_bar_display_driver_top.sv
// ----------------------------------------------------------------------------
// ecg_bar_display_driver_top - ECG moving-average filter driving an LED bar
// Sample beats (tuser kind 0) clamp at zero into an 8-tap shift window with a
// running sum; the average is the sum over 8. Tick beats (kind 1) count, and
// the first tick and every refresh_divider-th tick after it refresh the bar:
// each duty decays by decay_step, the bar LED for the average and LED 0 take
// marker_level, and 8 pin/duty frames leave, pins 0 upward, tlast on the
// eighth. A sample beat with leads_off set clears every duty, sends 8 zero
// frames and leaves the block ignoring all beats until reset. Sample beats and
// ticks without refresh leave req_tready high; a refreshing tick or a leads-off
// sample holds req_tready low until its last frame beat is taken, because the
// frames leave from the head of the LED cell chain as it rotates by one cell
// per beat and no request is taken meanwhile.
// ----------------------------------------------------------------------------
module ecg_bar_display_driver_top
   import ecgbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [12:0] sample
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: [0] kind, [1] leads_off
   input  logic [1:0]            req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rsp_tdata: [2:0] pin_index, [10:3] duty
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   logic [CFG_W-1:0]   decay_step_ff, decay_step_in;
   logic [CFG_W-1:0]   refresh_div_ff, refresh_div_in;
   logic [CFG_W-1:0]   marker_level_ff, marker_level_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CFG_W-1:0]   tick_count_ff, tick_count_in;
   logic               active_ff, active_in;
   logic               busy_ff, busy_in;
   logic [LED_W-1:0]   frame_cnt_ff, frame_cnt_in;

   logic               req_fire, rsp_fire, frame_last;
   logic               take_sample, take_tick, do_refresh, lead_trip;
   logic [SAMPLE_W-1:0] sample;
   logic [VALUE_W-1:0] clamped;
   logic [VALUE_W-1:0] average;
   logic [LED_W-1:0]   bar_idx;
   logic [CFG_W:0]     tick_next;
   led_ctl_type        led_ctl;

   logic [VALUE_W-1:0] ring_q [WINDOW];
   logic [DUTY_W-1:0]  duty_q [LED_COUNT];

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign frame_last = (frame_cnt_ff == LED_W'(LED_COUNT - 1));

   assign sample      = req_tdata[SAMPLE_W-1:0];
   assign clamped     = sample[SAMPLE_W-1] ? '0 : sample[VALUE_W-1:0];
   assign take_sample = req_fire && active_ff && (req_tuser[0] == KIND_SAMPLE);
   assign take_tick   = req_fire && active_ff && (req_tuser[0] == KIND_TICK);
   assign do_refresh  = take_tick && (tick_count_ff == '0);
   assign lead_trip   = take_sample && req_tuser[1];

   assign average = sum_ff[SUM_W-1:WIN_W];
   assign bar_idx = bar_led(average);

   // sample window: a shift chain, the last tap is the oldest sample
   for (genvar i = 0; i < WINDOW; i++) begin : g_ring
      ecgbd_ring_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (take_sample),
         .value_prev ((i == 0) ? clamped : ring_q[(i == 0) ? 0 : i - 1]),
         .value      (ring_q[i])
      );
   end

   always_comb begin
      led_ctl.decay_step   = decay_step_ff;
      led_ctl.marker_level = marker_level_ff;
      if (lead_trip)       led_ctl.op = LED_CLEAR;
      else if (do_refresh) led_ctl.op = LED_REFRESH;
      else if (rsp_fire)   led_ctl.op = LED_ROTATE;
      else                 led_ctl.op = LED_HOLD;
   end

   // LED chain rotates toward cell 0, which feeds the frame output
   for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
      ecgbd_led_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (led_ctl),
         .is_marker ((i == 0) || (bar_idx == LED_W'(i))),
         .duty_next (duty_q[(i + 1) % LED_COUNT]),
         .duty      (duty_q[i])
      );
   end

   always_comb begin
      decay_step_in   = decay_step_ff;
      refresh_div_in  = refresh_div_ff;
      marker_level_in = marker_level_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DECAY_STEP:   decay_step_in   = csr_data;
            CSR_REFRESH_DIV:  refresh_div_in  = csr_data;
            CSR_MARKER_LEVEL: marker_level_in = csr_data;
            default:          ;
         endcase
      end

      sum_in = take_sample ? sum_ff - SUM_W'(ring_q[WINDOW-1]) + SUM_W'(clamped) : sum_ff;

      tick_next     = {1'b0, tick_count_ff} + 1'b1;
      tick_count_in = tick_count_ff;
      if (take_tick) begin
         // wrap on reaching the divider; a divider of zero wraps every tick
         tick_count_in = (tick_next >= {1'b0, refresh_div_ff}) ? '0 : tick_next[CFG_W-1:0];
      end

      active_in    = lead_trip ? 1'b0 : active_ff;
      busy_in      = busy_ff;
      frame_cnt_in = frame_cnt_ff;
      if (lead_trip || do_refresh) begin
         busy_in = 1'b1;
      end else if (rsp_fire) begin
         frame_cnt_in = frame_last ? '0 : frame_cnt_ff + 1'b1;
         if (frame_last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_step_ff   <= DECAY_STEP_RESET;
         refresh_div_ff  <= REFRESH_DIV_RESET;
         marker_level_ff <= MARKER_LEVEL_RESET;
         sum_ff          <= '0;
         tick_count_ff   <= '0;
         active_ff       <= 1'b1;
         busy_ff         <= 1'b0;
         frame_cnt_ff    <= '0;
      end else begin
         decay_step_ff   <= decay_step_in;
         refresh_div_ff  <= refresh_div_in;
         marker_level_ff <= marker_level_in;
         sum_ff          <= sum_in;
         tick_count_ff   <= tick_count_in;
         active_ff       <= active_in;
         busy_ff         <= busy_in;
         frame_cnt_ff    <= frame_cnt_in;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = frame_last;
   assign rsp_tdata  = RSP_DATA_W'({duty_q[0], PIN_W'(frame_cnt_ff)});

endmodule

// File: rtl/core/ecgbd_checker.sv
// ----------------------------------------------------------------------------
// ecgbd_checker - port-level checks of the ECG bar display driver
// Watches frame ordering, burst framing and request blocking at the ports.
// ----------------------------------------------------------------------------
module ecgbd_checker
   import ecgbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   // hold a stalled frame beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled frame beat changed");

   a_no_req_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken during a frame burst");

   a_pin_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[2:0] == 3'($past(rsp_tdata[2:0]) + 3'd1)))
      else $error("frame pins out of order");

   a_last_on_top_pin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[2:0] == 3'(LED_COUNT - 1))))
      else $error("tlast not on the final pin");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("burst did not end after its last beat");

endmodule

bind ecg_bar_display_driver_top ecgbd_checker u_checker (.*);
